/* rtl/core/bls_pkg.sv */
package bls_pkg;

  localparam int DATA_W = 32;
  localparam int CFG_W  = 6;
  localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_SHOW = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SHOW
  } state_t;

  // One result beat
  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  value;
    logic                      last;
  } result_t;

endpackage

/* rtl/core/bls_ram.sv */
module bls_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [bls_pkg::DATA_W-1:0]    wdata,
  input  logic [AW-1:0]                 raddr,
  output logic [bls_pkg::DATA_W-1:0]    rdata
);

  logic [bls_pkg::DATA_W-1:0] store_r [DEPTH];
  logic [bls_pkg::DATA_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      store_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= store_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/bls_ctrl.sv */
module bls_ctrl #(
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH),
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [1:0]                        op,
  input  logic signed [bls_pkg::DATA_W-1:0] value_in,
  input  logic [CNT_W-1:0]                  cap,
  output logic                              busy,
  // memory side
  output logic                              mem_we,
  output logic [AW-1:0]                     mem_waddr,
  output logic [bls_pkg::DATA_W-1:0]        mem_wdata,
  output logic [AW-1:0]                     mem_raddr,
  input  logic [bls_pkg::DATA_W-1:0]        mem_rdata,
  // result side
  output logic                              res_strobe,
  output bls_pkg::result_t                  res
);

  bls_pkg::state_t  state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic             strobe_r, strobe_nxt;
  bls_pkg::result_t res_r, res_nxt;
  logic [CNT_W-1:0] count_dec;

  assign count_dec = count_r - CNT_W'(1);
  assign busy      = (state_r != bls_pkg::S_IDLE);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bls_pkg::S_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    res_r <= res_nxt;
  end

  // Next state, memory requests and result beat
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    strobe_nxt = 1'b0;
    res_nxt    = res_r;
    mem_we     = 1'b0;
    mem_waddr  = count_r[AW-1:0];
    mem_wdata  = value_in;
    mem_raddr  = count_dec[AW-1:0];
    case (state_r)
      bls_pkg::S_IDLE: begin
        if (start) begin
          case (bls_pkg::op_t'(op))
            bls_pkg::OP_PUSH: begin
              strobe_nxt = 1'b1;
              res_nxt    = '{status: bls_pkg::ST_OK, value: '0, last: 1'b1};
              if (count_r >= cap) begin
                res_nxt.status = bls_pkg::ST_OVERFLOW;
              end else begin
                mem_we    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            bls_pkg::OP_POP, bls_pkg::OP_PEEK: begin
              if (count_r == '0) begin
                strobe_nxt = 1'b1;
                res_nxt    = '{status: bls_pkg::ST_EMPTY, value: '0, last: 1'b1};
              end else begin
                // read top now, answer when the data returns
                state_nxt = bls_pkg::S_READ;
                if (bls_pkg::op_t'(op) == bls_pkg::OP_POP) begin
                  count_nxt = count_dec;
                end
              end
            end
            bls_pkg::OP_SHOW: begin
              if (count_r == '0) begin
                strobe_nxt = 1'b1;
                res_nxt    = '{status: bls_pkg::ST_EMPTY, value: '0, last: 1'b1};
              end else begin
                idx_nxt   = count_dec[AW-1:0];
                state_nxt = bls_pkg::S_SHOW;
              end
            end
            default: begin
              state_nxt = bls_pkg::S_IDLE;
            end
          endcase
        end
      end
      bls_pkg::S_READ: begin
        strobe_nxt = 1'b1;
        res_nxt    = '{status: bls_pkg::ST_OK, value: mem_rdata, last: 1'b1};
        state_nxt  = bls_pkg::S_IDLE;
      end
      bls_pkg::S_SHOW: begin
        // data for idx_r is on the read port; fetch the one below
        strobe_nxt = 1'b1;
        res_nxt    = '{status: bls_pkg::ST_OK, value: mem_rdata, last: (idx_r == '0)};
        mem_raddr  = idx_r - AW'(1);
        if (idx_r == '0) begin
          state_nxt = bls_pkg::S_IDLE;
        end else begin
          idx_nxt = idx_r - AW'(1);
        end
      end
      default: begin
        state_nxt = bls_pkg::S_IDLE;
      end
    endcase
  end

  assign res_strobe = strobe_r;
  assign res        = res_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == bls_pkg::S_IDLE) && (count_r < cap))
    else $error("memory write without room");

  a_read_answers: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bls_pkg::S_READ |=> strobe_r && res_r.last)
    else $error("pop or peek gave no final beat");

  a_overflow_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r && (res_r.status == bls_pkg::ST_OVERFLOW) |-> $stable(count_r))
    else $error("refused push changed the count");

  a_show_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bls_pkg::S_SHOW) && (idx_r == '0) |=> state_r == bls_pkg::S_IDLE)
    else $error("show walk did not end at the bottom");

endmodule

/* rtl/core/bounded_lifo_stack_top.sv */
// LIFO stack of signed 32-bit words, capacity set by cfg_wdata (saturated to DEPTH).
// Input: drive in_op and in_value_in with start high; the beat is taken on a
// clock edge where start is high and busy is low. Ops: push, pop, peek, show.
// Results: out_status, out_value_out, out_last are valid for one cycle while
// out_strobe is high. The receiver cannot stall; every beat must be taken.
// Result timing, shaped by the registered read port of the word memory:
//   push      one result in the cycle after accept, busy stays low, so a new item can be taken meanwhile
//   pop/peek  one result, registered after the S_READ state; busy while in S_READ
//   show      N results (N entries), top first, the first registered after
//             S_SHOW is entered and then one per cycle; busy through the walk
//   empty pop/peek/show: a single status beat in the cycle after accept
// out_last marks the final beat of each item. Push results carry value zero.
// Configuration: cfg_we writes the capacity register; write only while idle.
// Reset (rst_n low, synchronous) empties the stack and sets capacity to 32.
// Memory contents are not cleared; only entries below the count are read.
module bounded_lifo_stack_top #(
  parameter int DEPTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_op,
  input  logic signed [bls_pkg::DATA_W-1:0] in_value_in,
  output logic                              out_strobe,
  output logic [1:0]                        out_status,
  output logic signed [bls_pkg::DATA_W-1:0] out_value_out,
  output logic                              out_last,
  input  logic                              cfg_we,
  input  logic [bls_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [bls_pkg::CFG_W-1:0]  size_r;
  logic [CNT_W-1:0]           cap;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [AW-1:0]              mem_raddr;
  logic [bls_pkg::DATA_W-1:0] mem_wdata;
  logic [bls_pkg::DATA_W-1:0] mem_rdata;
  bls_pkg::result_t           res;

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= bls_pkg::CFG_RESET;
    end else if (cfg_we) begin
      size_r <= cfg_wdata;
    end
  end

  // Capacity in use, never above the built depth
  always_comb begin
    if (int'(size_r) > DEPTH) begin
      cap = CNT_W'(DEPTH);
    end else begin
      cap = CNT_W'(size_r);
    end
  end

  bls_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .op         (in_op),
    .value_in   (in_value_in),
    .cap        (cap),
    .busy       (busy),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .res_strobe (out_strobe),
    .res        (res)
  );

  bls_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_status    = res.status;
  assign out_value_out = res.value;
  assign out_last      = res.last;

endmodule
